/* design/msp_response_frame_checker_assert.svh */
// Assertion macros for the response frame checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MSP_RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define MSP_RESPONSE_FRAME_CHECKER_ASSERT_SVH

// checked outside reset only
`define MSP_RFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define MSP_RFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/msp_rfc_pkg.sv */
// Types and constants of the response frame checker.
// No dependencies.
package msp_rfc_pkg;

  localparam logic [7:0] DirReply   = 8'h3E;  // '>'
  localparam int unsigned PosW      = 9;
  localparam logic [PosW-1:0] PosDirection = 9'd2;
  localparam logic [PosW-1:0] PosSize      = 9'd3;
  localparam logic [PosW-1:0] PosCommand   = 9'd4;
  localparam logic [PosW-1:0] PosPayload   = 9'd5;

  localparam int unsigned AddrW = 3;
  localparam logic RegCommand = 1'b0;
  localparam logic RegSize    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_HEADER   = 3'd2,
    ST_SIZE     = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] expected_command;
    logic [7:0] expected_payload_size;
  } cfg_t;

endpackage

/* design/msp_rfc_if.sv */
// Valid/ready channels of the response frame checker: received bytes in,
// payload bytes and frame status out. No dependencies.
interface msp_rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       window_closed;

  modport source (output valid, output rx_byte, output window_closed, input ready);
  modport sink   (input valid, input rx_byte, input window_closed, output ready);
endinterface

interface msp_rfc_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] payload_byte;
  logic [2:0] frame_status;

  modport source (output valid, output is_status, output payload_byte,
                  output frame_status, input ready);
  modport sink   (input valid, input is_status, input payload_byte,
                  input frame_status, output ready);
endinterface

/* design/msp_response_frame_checker.sv */
// Response frame checker: one received byte per transfer in, payload bytes
// and one frame status per frame out; takes a new byte every clock cycle
// while the output is not stalled. Each byte passes an input register and a
// result register before its result is presented; output stalls back up
// through those two registers only. Depends on msp_rfc_pkg, the channel
// interfaces, msp_rfc_cfg and msp_rfc_core. Registers: 0x0 expected
// command, 0x4 expected payload size.
module msp_response_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_rfc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  msp_rfc_in_if.sink                     in_i,
  msp_rfc_out_if.source                  out_o
);
  import msp_rfc_pkg::*;

  cfg_t cfg;

  msp_rfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msp_rfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`include "msp_response_frame_checker_assert.svh"

  `MSP_RFC_ASSERT(a_status_no_byte,
    out_o.valid && out_o.is_status |-> out_o.payload_byte == 8'd0,
    "status transfer carries a payload byte")
  `MSP_RFC_ASSERT(a_byte_no_status,
    out_o.valid && !out_o.is_status |-> out_o.frame_status == ST_OK,
    "payload transfer carries a status")
  `MSP_RFC_ASSERT_ALWAYS(a_apb_ready, pready, "pready dropped")

endmodule

/* design/msp_rfc_cfg.sv */
// APB-style register block: expected command and expected payload size.
// Depends on msp_rfc_pkg.
module msp_rfc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_rfc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output msp_rfc_pkg::cfg_t              cfg_o
);
  import msp_rfc_pkg::*;

  logic [7:0] cmd_q, cmd_d;
  logic [7:0] size_q, size_d;
  logic       wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cmd_d  = cmd_q;
    size_d = size_q;
    if (wr) begin
      case (paddr[2])
        RegCommand: cmd_d  = pwdata[7:0];
        RegSize:    size_d = pwdata[7:0];
        default:    cmd_d  = cmd_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= '0;
      size_q <= '0;
    end else begin
      cmd_q  <= cmd_d;
      size_q <= size_d;
    end
  end

  assign prdata = {24'd0, (paddr[2] == RegSize) ? size_q : cmd_q};
  assign cfg_o  = '{expected_command: cmd_q, expected_payload_size: size_q};

endmodule

/* design/msp_rfc_core.sv */
// Frame checker datapath: input register, frame state, result register.
// Depends on msp_rfc_pkg and the channel interfaces.
module msp_rfc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msp_rfc_pkg::cfg_t cfg_i,
  msp_rfc_in_if.sink        in_i,
  msp_rfc_out_if.source     out_o
);
  import msp_rfc_pkg::*;

  // input register
  logic            s1_valid_q, s1_valid_d;
  logic [7:0]      s1_byte_q;
  logic            s1_closed_q;

  // frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      xor_q, xor_d;
  logic            hdr_bad_q, hdr_bad_d;
  logic            size_bad_q, size_bad_d;

  // result register
  logic            o_valid_q, o_valid_d;
  logic            o_status_q;
  logic [7:0]      o_byte_q;
  status_e         o_code_q;

  logic            in_fire, s1_fire, out_free, has_res, res_status;
  logic [PosW-1:0] last_pos;
  status_e         res_code;
  logic [7:0]      res_byte;

  assign last_pos = PosPayload + {1'b0, cfg_i.expected_payload_size};
  assign out_free = !o_valid_q || out_o.ready;
  assign has_res  = s1_closed_q || (pos_q >= PosPayload);
  assign s1_fire  = s1_valid_q && (!has_res || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    pos_d      = pos_q;
    xor_d      = xor_q;
    hdr_bad_d  = hdr_bad_q;
    size_bad_d = size_bad_q;
    res_status = 1'b0;
    res_code   = ST_OK;
    res_byte   = s1_byte_q;
    if (s1_closed_q || pos_q >= last_pos) begin
      res_status = 1'b1;
      res_byte   = '0;
      if (s1_closed_q)                res_code = ST_SHORT;
      else if (hdr_bad_q)             res_code = ST_HEADER;
      else if (size_bad_q)            res_code = ST_SIZE;
      else if (xor_q != s1_byte_q)    res_code = ST_CHECKSUM;
      else                            res_code = ST_OK;
      pos_d      = '0;
      xor_d      = '0;
      hdr_bad_d  = 1'b0;
      size_bad_d = 1'b0;
    end else begin
      pos_d = pos_q + 1'b1;
      if (pos_q == PosDirection) begin
        if (s1_byte_q != DirReply) hdr_bad_d = 1'b1;
      end else if (pos_q == PosSize) begin
        if (s1_byte_q != cfg_i.expected_payload_size) size_bad_d = 1'b1;
        xor_d = s1_byte_q;
      end else if (pos_q == PosCommand) begin
        if (s1_byte_q != cfg_i.expected_command) hdr_bad_d = 1'b1;
        xor_d = xor_q ^ s1_byte_q;
      end else if (pos_q >= PosPayload) begin
        xor_d = xor_q ^ s1_byte_q;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)      s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
    o_valid_d = o_valid_q;
    if (s1_fire && has_res) o_valid_d = 1'b1;
    else if (out_o.ready)   o_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
      pos_q      <= '0;
      xor_q      <= '0;
      hdr_bad_q  <= 1'b0;
      size_bad_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      o_valid_q  <= o_valid_d;
      if (s1_fire) begin
        pos_q      <= pos_d;
        xor_q      <= xor_d;
        hdr_bad_q  <= hdr_bad_d;
        size_bad_q <= size_bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q   <= in_i.rx_byte;
      s1_closed_q <= in_i.window_closed;
    end
    if (s1_fire && has_res) begin
      o_status_q <= res_status;
      o_byte_q   <= res_byte;
      o_code_q   <= res_code;
    end
  end

  assign out_o.valid        = o_valid_q;
  assign out_o.is_status    = o_status_q;
  assign out_o.payload_byte = o_byte_q;
  assign out_o.frame_status = o_code_q;

endmodule
